// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the multi-click decoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/bmc_pkg.sv =====
// ----------------------------------------------------------------------------
// bmc_pkg
// Types and constants shared by the button multi-click decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bmc_pkg;

  localparam int unsigned TickW  = 12;
  localparam int unsigned TallyW = 4;
  localparam int unsigned DebW   = 10;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned EventW = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  localparam int unsigned ModeCount = 3;

  typedef logic [TickW-1:0]  tick_t;
  typedef logic [TallyW-1:0] tally_t;
  typedef logic [ModeW-1:0]  mode_t;

  localparam tick_t  TickMax  = {TickW{1'b1}};
  localparam tally_t TallyMax = {TallyW{1'b1}};
  localparam mode_t  ModeLast = mode_t'(ModeCount - 1);

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegDebounce = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWindow   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegToggle   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMode     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSensors  = 3'd4;

  typedef enum logic [EventW-1:0] {
    EvNone     = 3'd0,
    EvStarted  = 3'd1,
    EvStopped  = 3'd2,
    EvRefused  = 3'd3,
    EvModeAdv  = 3'd4,
    EvIgnored  = 3'd5
  } event_e;

  typedef struct packed {
    logic [DebW-1:0] debounce_ticks;
    tick_t           click_window_ticks;
    tally_t          toggle_clicks;
    tally_t          mode_clicks;
    logic            sensors_ready;
  } cfg_t;

  typedef struct packed {
    logic   streaming_on;
    mode_t  wear_mode;
    logic   stable_level;
    event_e event_code;
    tally_t group_clicks;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/bmc_cfg.sv =====
// ----------------------------------------------------------------------------
// bmc_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bmc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [bmc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output bmc_pkg::cfg_t                      cfg_o
);

  bmc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bmc_pkg::RegDebounce: cfg_d.debounce_ticks     = cfg_wdata_i[bmc_pkg::DebW-1:0];
        bmc_pkg::RegWindow:   cfg_d.click_window_ticks = cfg_wdata_i[bmc_pkg::TickW-1:0];
        bmc_pkg::RegToggle:   cfg_d.toggle_clicks      = cfg_wdata_i[bmc_pkg::TallyW-1:0];
        bmc_pkg::RegMode:     cfg_d.mode_clicks        = cfg_wdata_i[bmc_pkg::TallyW-1:0];
        bmc_pkg::RegSensors:  cfg_d.sensors_ready      = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks     <= 10'd50;
      cfg_q.click_window_ticks <= 12'd800;
      cfg_q.toggle_clicks      <= 4'd3;
      cfg_q.mode_clicks        <= 4'd6;
      cfg_q.sensors_ready      <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/bmc_core.sv =====
// ----------------------------------------------------------------------------
// bmc_core
// Debounce, click grouping and group interpretation for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic          button_raw_i,
  input  bmc_pkg::cfg_t      cfg_i,
  output bmc_pkg::result_t   res_o
);

  logic            raw_seen_q, raw_seen_d;
  logic            stable_q, stable_d;
  bmc_pkg::tick_t  since_chg_q, since_chg_d, chg_inc;
  bmc_pkg::tick_t  since_clk_q, since_clk_d, clk_inc;
  bmc_pkg::tally_t tally_q, tally_d, tally_base, tally_cnt, group;
  logic            stream_q, stream_d;
  bmc_pkg::mode_t  mode_q, mode_d;
  bmc_pkg::event_e ev;
  logic            click, expire;

  always_comb begin
    chg_inc = (since_chg_q == bmc_pkg::TickMax) ? bmc_pkg::TickMax
                                                : bmc_pkg::tick_t'(since_chg_q + 1'b1);
    clk_inc = (since_clk_q == bmc_pkg::TickMax) ? bmc_pkg::TickMax
                                                : bmc_pkg::tick_t'(since_clk_q + 1'b1);

    raw_seen_d  = button_raw_i;
    since_chg_d = (button_raw_i != raw_seen_q) ? '0 : chg_inc;
    stable_d    = (since_chg_d > {2'b00, cfg_i.debounce_ticks}) ? button_raw_i : stable_q;

    // A release edge of the debounced level is one click.
    click      = !stable_q && stable_d;
    tally_base = (clk_inc > cfg_i.click_window_ticks) ? '0 : tally_q;
    if (click) begin
      tally_cnt   = (tally_base == bmc_pkg::TallyMax) ? tally_base
                                                      : bmc_pkg::tally_t'(tally_base + 1'b1);
      since_clk_d = '0;
    end else begin
      tally_cnt   = tally_q;
      since_clk_d = clk_inc;
    end

    expire   = (tally_cnt != '0) && (since_clk_d > cfg_i.click_window_ticks);
    group    = expire ? tally_cnt : '0;
    tally_d  = expire ? '0 : tally_cnt;
    stream_d = stream_q;
    mode_d   = mode_q;
    ev       = bmc_pkg::EvNone;

    if (expire) begin
      if (tally_cnt == cfg_i.toggle_clicks) begin
        if (stream_q) begin
          stream_d = 1'b0;
          ev       = bmc_pkg::EvStopped;
        end else if (cfg_i.sensors_ready) begin
          stream_d = 1'b1;
          ev       = bmc_pkg::EvStarted;
        end else begin
          ev = bmc_pkg::EvRefused;
        end
      end else if (tally_cnt >= cfg_i.mode_clicks) begin
        mode_d = (mode_q >= bmc_pkg::ModeLast) ? '0 : bmc_pkg::mode_t'(mode_q + 1'b1);
        ev     = bmc_pkg::EvModeAdv;
      end else begin
        ev = bmc_pkg::EvIgnored;
      end
    end

    res_o.streaming_on = stream_d;
    res_o.wear_mode    = mode_d;
    res_o.stable_level = stable_d;
    res_o.event_code   = ev;
    res_o.group_clicks = group;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_seen_q  <= 1'b1;
      stable_q    <= 1'b1;
      since_chg_q <= bmc_pkg::TickMax;
      since_clk_q <= bmc_pkg::TickMax;
      tally_q     <= '0;
      stream_q    <= 1'b0;
      mode_q      <= '0;
    end else if (step_i) begin
      raw_seen_q  <= raw_seen_d;
      stable_q    <= stable_d;
      since_chg_q <= since_chg_d;
      since_clk_q <= since_clk_d;
      tally_q     <= tally_d;
      stream_q    <= stream_d;
      mode_q      <= mode_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/button_multi_click_decoder.sv =====
// ----------------------------------------------------------------------------
// button_multi_click_decoder
// Debounces an active-low button sampled once per millisecond tick and
// decodes groups of clicks into streaming and mode commands.
// ----------------------------------------------------------------------------
// Each request carries one tick of the raw button level and produces exactly
// one result request. The block takes one request per clock cycle unless
// stalled; it goes into the input register and then the result register, with
// the tick's whole update done by the logic between them. A result waiting in
// the result register does not block intake while the input register can
// still move forward, and a stalled result holds its payload. The debounced
// level follows the raw level once the raw level has stayed unchanged for
// more than debounce_ticks ticks; each release of the debounced level counts
// as one click. When more than click_window_ticks ticks pass after the last
// click of a group, the group is acted on: exactly toggle_clicks clicks flip
// streaming (turning it on is refused while sensors_ready is 0), otherwise
// mode_clicks or more clicks advance the mode through three values, and any
// other count is reported as ignored. Tick counters saturate at 4095 and the
// click count at 15. Configuration registers must only be written while no
// request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module button_multi_click_decoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port.
  input  wire logic                          cfg_we_i,
  input  wire logic [bmc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [bmc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Tick input channel.
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic                          button_raw_i,
  // Result channel.
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic                          streaming_on_o,
  output      logic [1:0]                    wear_mode_o,
  output      logic                          stable_level_o,
  output      logic [2:0]                    event_code_o,
  output      logic [3:0]                    group_clicks_o
);

  bmc_pkg::cfg_t    cfg;
  bmc_pkg::result_t res;

  // Input register.
  logic in_valid_q, in_valid_d;
  logic raw_q;

  // Result register.
  logic             out_valid_q, out_valid_d;
  bmc_pkg::result_t out_q;

  logic out_ready, in_ready, in_take, advance;

  // The result register can load when it is empty or being drained this
  // cycle; the input register can load when it is empty or moving forward.
  assign out_ready = !out_valid_q || !out_stall_i;
  assign advance   = in_valid_q && out_ready;
  assign in_ready  = !in_valid_q || out_ready;
  assign in_take   = in_valid_i && in_ready;

  assign in_stall_o = !in_ready;

  always_comb begin
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end

    if (out_ready) begin
      out_valid_d = advance;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      raw_q <= button_raw_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  bmc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The tick state advances exactly when a tick moves into the result register.
  bmc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .button_raw_i (raw_q),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  assign out_valid_o    = out_valid_q;
  assign streaming_on_o = out_q.streaming_on;
  assign wear_mode_o    = out_q.wear_mode;
  assign stable_level_o = out_q.stable_level;
  assign event_code_o   = out_q.event_code;
  assign group_clicks_o = out_q.group_clicks;

endmodule

`default_nettype wire

// ===== sv/bmc_checker.sv =====
// ----------------------------------------------------------------------------
// bmc_checker
// Port-level checks on the result channel of the multi-click decoder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bmc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       streaming_on_o,
  input wire logic [1:0] wear_mode_o,
  input wire logic       stable_level_o,
  input wire logic [2:0] event_code_o,
  input wire logic [3:0] group_clicks_o
);

  // A stalled result stays valid and unchanged.
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable({streaming_on_o, wear_mode_o, stable_level_o, event_code_o, group_clicks_o}))

  // A group size is reported exactly when a group was acted on.
  `ASSERT_IMPLY(a_group, clk_i, rst_ni, out_valid_o, (event_code_o == bmc_pkg::EvNone) == (group_clicks_o == 4'd0))

  // The mode index never leaves its range.
  `ASSERT_IMPLY(a_mode, clk_i, rst_ni, out_valid_o, wear_mode_o <= bmc_pkg::ModeLast)

  // Start, stop and refused events agree with the streaming flag they report.
  `ASSERT_IMPLY(a_start, clk_i, rst_ni, out_valid_o && (event_code_o == bmc_pkg::EvStarted), streaming_on_o)
  `ASSERT_IMPLY(a_stop, clk_i, rst_ni, out_valid_o && (event_code_o == bmc_pkg::EvStopped || event_code_o == bmc_pkg::EvRefused), !streaming_on_o)

endmodule

bind button_multi_click_decoder bmc_checker u_bmc_checker (.*);

`default_nettype wire
